@@ rtl/salc_pkg.sv @@
// shared constants and types of the set-associative lru cache tag model
`default_nettype none

package salc_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int TAG_W            = 64;
    localparam int CNT_W            = 32;

    localparam logic [1:0] KIND_MODIFY = 2'd2;

    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_WAYS_IN_USE = 2'd1;
    localparam logic [1:0] CFG_BLOCK_BITS  = 2'd2;

    localparam logic [2:0] SET_BITS_RST    = 3'd4;
    localparam logic [3:0] WAYS_IN_USE_RST = 4'd1;
    localparam logic [5:0] BLOCK_BITS_RST  = 6'd4;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } salc_state_t;

    typedef struct packed {
        logic hit;
        logic evicted;
    } salc_flags_t;

endpackage

`default_nettype wire

@@ rtl/salc_set_ram.sv @@
// set memory: one row holds every way of a set, registered read
`default_nettype none

module salc_set_ram #(
    parameter int ADDR_W = salc_pkg::MAX_SET_BITS_DEF,
    parameter int ROWS   = 1 << salc_pkg::MAX_SET_BITS_DEF,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/salc_way_logic.sv @@
// way compare, victim choice and age update of one set row
`default_nettype none

module salc_way_logic #(
    parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEF,
    localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int WAY_W = 1 + salc_pkg::TAG_W + AGE_W,
    localparam int ROW_W = MAX_WAYS * WAY_W,
    localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  wire logic [ROW_W-1:0]            row_in,
    input  wire logic [salc_pkg::TAG_W-1:0]  tag,
    input  wire logic [MAX_WAYS-1:0]         way_en,
    output logic      [ROW_W-1:0]            row_out,
    output salc_pkg::salc_flags_t            flags,
    output logic      [WAY_IDX_W-1:0]        way
);

    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

    logic [MAX_WAYS-1:0]        valid;
    logic [salc_pkg::TAG_W-1:0] tags [MAX_WAYS];
    logic [AGE_W-1:0]           ages [MAX_WAYS];
    logic                       hit;
    logic [WAY_IDX_W-1:0]       hit_way;
    logic                       free_found;
    logic [WAY_IDX_W-1:0]       free_way;
    logic [WAY_IDX_W-1:0]       old_way;
    logic [AGE_W-1:0]           oldest;
    logic [AGE_W-1:0]           limit_age;

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            valid[i] = row_in[i*WAY_W];
            tags[i]  = row_in[i*WAY_W + 1 +: salc_pkg::TAG_W];
            ages[i]  = row_in[i*WAY_W + 1 + salc_pkg::TAG_W +: AGE_W];
        end
    end

    always_comb
    begin
        hit        = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        // lowest way wins: scan from the top
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (way_en[i] && valid[i] && tags[i] == tag)
            begin
                hit     = 1'b1;
                hit_way = WAY_IDX_W'(i);
            end
            if (way_en[i] && !valid[i])
            begin
                free_found = 1'b1;
                free_way   = WAY_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        old_way = '0;
        oldest  = ages[0];
        for (int i = 1; i < MAX_WAYS; i++)
        begin
            if (way_en[i] && ages[i] > oldest)
            begin
                oldest  = ages[i];
                old_way = WAY_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        flags.hit     = hit;
        flags.evicted = !hit && !free_found;
        if (hit)
        begin
            way = hit_way;
        end
        else if (free_found)
        begin
            way = free_way;
        end
        else
        begin
            way = old_way;
        end
        limit_age = ages[hit_way];

        row_out = row_in;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (WAY_IDX_W'(i) == way)
            begin
                row_out[i*WAY_W]                                = 1'b1;
                row_out[i*WAY_W + 1 +: salc_pkg::TAG_W]         = tag;
                row_out[i*WAY_W + 1 + salc_pkg::TAG_W +: AGE_W] = '0;
            end
            else if (way_en[i] && valid[i] && ages[i] < AGE_MAX &&
                     (!hit || ages[i] < limit_age))
            begin
                row_out[i*WAY_W + 1 + salc_pkg::TAG_W +: AGE_W] = ages[i] + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/set_assoc_lru_cache_tag_sim_top.sv @@
// top level: control, configuration, totals and result registers of the cache tag model
`default_nettype none

// On each access the accept edge reads the set row from the set memory, and
// the next cycle compares all ways at once, picks the way and writes the row back. busy is
// high for that one cycle, the result is on the result ports for one cycle marked by done,
// and the next access may start in that same cycle. The receiver cannot stall results, so
// done must be taken when it appears. After reset a clearing pass writes every set row, one
// a cycle, with busy high; configuration writes are taken at any time.
module set_assoc_lru_cache_tag_sim_top #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [63:0]                address,
    input  wire logic [1:0]                 access_kind,
    output logic                            done,
    output logic                            was_hit,
    output logic                            was_evicted,
    output logic                            extra_hit,
    output logic [2:0]                      chosen_way,
    output logic [salc_pkg::CNT_W-1:0]      total_hits,
    output logic [salc_pkg::CNT_W-1:0]      total_misses,
    output logic [salc_pkg::CNT_W-1:0]      total_evictions,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [5:0]                 cfg_data
);

    localparam int SET_IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ROWS      = 1 << MAX_SET_BITS;
    localparam int AGE_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W     = 1 + salc_pkg::TAG_W + AGE_W;
    localparam int ROW_W     = MAX_WAYS * WAY_W;
    localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [SET_IDX_W-1:0] LAST_ROW = SET_IDX_W'(ROWS - 1);

    salc_pkg::salc_state_t state_reg, state_next;

    logic [2:0]                 set_bits_reg;
    logic [3:0]                 ways_in_use_reg;
    logic [5:0]                 block_bits_reg;
    logic [SET_IDX_W-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [SET_IDX_W-1:0]       set_reg;
    logic [salc_pkg::TAG_W-1:0] tag_reg;
    logic                       modify_reg;
    logic [salc_pkg::CNT_W-1:0] hit_total_reg, hit_total_next;
    logic [salc_pkg::CNT_W-1:0] miss_total_reg, miss_total_next;
    logic [salc_pkg::CNT_W-1:0] evict_total_reg, evict_total_next;
    logic                       done_reg;
    logic                       was_hit_reg;
    logic                       was_evicted_reg;
    logic                       extra_hit_reg;
    logic [2:0]                 chosen_way_reg;

    logic                       accept;
    logic [2:0]                 sb_eff;
    logic [63:0]                addr_shifted;
    logic [SET_IDX_W-1:0]       set_idx;
    logic [6:0]                 tag_shift;
    logic [salc_pkg::TAG_W-1:0] tag_in;
    logic [MAX_WAYS-1:0]        way_en;

    logic                       ram_we;
    logic [SET_IDX_W-1:0]       ram_waddr;
    logic [ROW_W-1:0]           ram_wdata;
    logic [ROW_W-1:0]           ram_rdata;
    logic [ROW_W-1:0]           row_upd;
    salc_pkg::salc_flags_t      flags;
    logic [WAY_IDX_W-1:0]       way;
    logic [WAY_IDX_W+2:0]       way_ext;

    logic [salc_pkg::CNT_W:0]   hit_sum;
    logic [salc_pkg::CNT_W:0]   miss_sum;
    logic [salc_pkg::CNT_W:0]   evict_sum;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // address split
    always_comb
    begin
        sb_eff       = (32'(set_bits_reg) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_reg;
        addr_shifted = address >> block_bits_reg;
        set_idx      = addr_shifted[SET_IDX_W-1:0] & ~({SET_IDX_W{1'b1}} << sb_eff);
        tag_shift    = {1'b0, block_bits_reg} + {4'b0, sb_eff};
        tag_in       = tag_shift[6] ? '0 : (address >> tag_shift[5:0]);
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            way_en[i] = (i == 0) || (32'(i) < 32'(ways_in_use_reg));
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        busy         = 1'b1;
        ram_we       = 1'b0;
        ram_waddr    = set_reg;
        ram_wdata    = row_upd;
        case (state_reg)
            salc_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ROW)
                begin
                    state_next = salc_pkg::ST_IDLE;
                end
            end
            salc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    state_next = salc_pkg::ST_LOOKUP;
                end
            end
            salc_pkg::ST_LOOKUP:
            begin
                ram_we     = 1'b1;
                state_next = salc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = salc_pkg::ST_CLEAR;
            end
        endcase
    end

    salc_set_ram #(
        .ADDR_W (SET_IDX_W),
        .ROWS   (ROWS),
        .DATA_W (ROW_W)
    ) u_set_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (set_idx),
        .rdata (ram_rdata)
    );

    salc_way_logic #(
        .MAX_WAYS (MAX_WAYS)
    ) u_way_logic (
        .row_in  (ram_rdata),
        .tag     (tag_reg),
        .way_en  (way_en),
        .row_out (row_upd),
        .flags   (flags),
        .way     (way)
    );

    // saturating totals
    always_comb
    begin
        hit_sum   = {1'b0, hit_total_reg} + (salc_pkg::CNT_W + 1)'(flags.hit)
                    + (salc_pkg::CNT_W + 1)'(modify_reg);
        miss_sum  = {1'b0, miss_total_reg} + (salc_pkg::CNT_W + 1)'(!flags.hit);
        evict_sum = {1'b0, evict_total_reg} + (salc_pkg::CNT_W + 1)'(flags.evicted);
        hit_total_next   = hit_sum[salc_pkg::CNT_W] ? '1 : hit_sum[salc_pkg::CNT_W-1:0];
        miss_total_next  = miss_sum[salc_pkg::CNT_W] ? '1 : miss_sum[salc_pkg::CNT_W-1:0];
        evict_total_next = evict_sum[salc_pkg::CNT_W] ? '1 : evict_sum[salc_pkg::CNT_W-1:0];
        way_ext          = {3'b000, way};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= salc_pkg::ST_CLEAR;
            clr_cnt_reg     <= '0;
            set_bits_reg    <= salc_pkg::SET_BITS_RST;
            ways_in_use_reg <= salc_pkg::WAYS_IN_USE_RST;
            block_bits_reg  <= salc_pkg::BLOCK_BITS_RST;
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= (state_reg == salc_pkg::ST_LOOKUP);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    salc_pkg::CFG_SET_BITS:    set_bits_reg    <= cfg_data[2:0];
                    salc_pkg::CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_data[3:0];
                    salc_pkg::CFG_BLOCK_BITS:  block_bits_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == salc_pkg::ST_LOOKUP)
            begin
                hit_total_reg   <= hit_total_next;
                miss_total_reg  <= miss_total_next;
                evict_total_reg <= evict_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg    <= set_idx;
            tag_reg    <= tag_in;
            modify_reg <= (access_kind == salc_pkg::KIND_MODIFY);
        end
        if (state_reg == salc_pkg::ST_LOOKUP)
        begin
            was_hit_reg     <= flags.hit;
            was_evicted_reg <= flags.evicted;
            extra_hit_reg   <= modify_reg;
            chosen_way_reg  <= way_ext[2:0];
        end
    end

    assign done            = done_reg;
    assign was_hit         = was_hit_reg;
    assign was_evicted     = was_evicted_reg;
    assign extra_hit       = extra_hit_reg;
    assign chosen_way      = chosen_way_reg;
    assign total_hits      = hit_total_reg;
    assign total_misses    = miss_total_reg;
    assign total_evictions = evict_total_reg;

    a_done_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == salc_pkg::ST_LOOKUP))
        else $error("result strobe without a lookup cycle");

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("accepted access did not hold busy for its lookup");

    a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && was_evicted |-> !was_hit)
        else $error("eviction flagged on a hit");

    a_lookup_writes_row: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == salc_pkg::ST_LOOKUP |-> ram_we && ram_waddr == set_reg)
        else $error("lookup cycle did not write back its set");

endmodule

`default_nettype wire

@@ test/tb_set_assoc_lru_cache_tag_sim_top.sv @@
// self-checking testbench for the set-associative lru cache tag model
`timescale 1ns / 100ps

module tb_set_assoc_lru_cache_tag_sim_top;

    localparam int MAX_SB     = salc_pkg::MAX_SET_BITS_DEF;
    localparam int MAX_W      = salc_pkg::MAX_WAYS_DEF;
    localparam int LINES      = (1 << MAX_SB) * MAX_W;
    localparam int RAND_ITEMS = 100;
    localparam int RAND_PHASES = 16;
    localparam int STALL_LIMIT = 1000;
    localparam int SHOW_LIMIT  = 10;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_STORE   = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic        extra;
        logic [2:0]  way;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
    } cache_outcome_t;

    typedef struct packed {
        logic        is_write;
        logic [1:0]  reg_idx;
        logic [5:0]  reg_val;
        logic [63:0] addr;
        logic [1:0]  kind;
        logic        typed;
        logic        hit;
        logic        evicted;
        logic [2:0]  way;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [63:0] address;
    logic [1:0]  access_kind;
    logic        done;
    logic        was_hit;
    logic        was_evicted;
    logic        extra_hit;
    logic [2:0]  chosen_way;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_evictions;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;

    // predictor copy of the tag store and settings
    logic        line_ok   [LINES];
    logic [63:0] line_tg   [LINES];
    logic [2:0]  line_rank [LINES];
    logic [31:0] hit_cnt;
    logic [31:0] miss_cnt;
    logic [31:0] evict_cnt;
    logic [2:0]  cfg_sb;
    logic [3:0]  cfg_ways;
    logic [5:0]  cfg_bb;

    cache_outcome_t outcome_q [$];
    script_row_t    script [$];
    logic [63:0]    addr_pool [$];

    int fails;
    int accesses;
    int directed_accesses;
    int reg_writes;
    int seen_hits;
    int seen_misses;
    int seen_evictions;
    int seen_modifies;
    int stall_cycles;

    set_assoc_lru_cache_tag_sim_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .address         (address),
        .access_kind     (access_kind),
        .done            (done),
        .was_hit         (was_hit),
        .was_evicted     (was_evicted),
        .extra_hit       (extra_hit),
        .chosen_way      (chosen_way),
        .total_hits      (total_hits),
        .total_misses    (total_misses),
        .total_evictions (total_evictions),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic script_row_t row_write(input logic [1:0] idx, input logic [5:0] val);
        script_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        return r;
    endfunction

    function automatic script_row_t row_access(input logic [63:0] a, input logic [1:0] k);
        script_row_t r;
        r = '0;
        r.addr = a;
        r.kind = k;
        return r;
    endfunction

    function automatic script_row_t row_typed(input logic [63:0] a, input logic [1:0] k,
                                              input logic h, input logic e, input logic [2:0] w);
        script_row_t r;
        r = row_access(a, k);
        r.typed   = 1'b1;
        r.hit     = h;
        r.evicted = e;
        r.way     = w;
        return r;
    endfunction

    // make way w the most recent; valid ways younger than limit age by one
    task automatic age_lines(input int base, input int nw, input int w, input int limit);
        int i;
        for (i = 0; i < nw; i++)
        begin
            if (i != w && line_ok[base + i] && int'(line_rank[base + i]) < limit &&
                int'(line_rank[base + i]) < MAX_W - 1)
                line_rank[base + i] = line_rank[base + i] + 3'd1;
        end
        line_rank[base + w] = 3'd0;
    endtask

    task automatic predict_access(input logic [63:0] a, input logic [1:0] k,
                                  output cache_outcome_t res);
        int          sb;
        int          nw;
        int          sh;
        int          base;
        int          w;
        int          i;
        logic [63:0] set_idx;
        logic [63:0] tg;
        logic [2:0]  oldest;
        bit          found;
        bit          vacant;
        sb = (int'(cfg_sb) > MAX_SB) ? MAX_SB : int'(cfg_sb);
        nw = (cfg_ways == 4'd0) ? 1 : ((int'(cfg_ways) > MAX_W) ? MAX_W : int'(cfg_ways));
        sh = int'(cfg_bb) + sb;
        set_idx = (a >> cfg_bb) & ((64'd1 << sb) - 64'd1);
        tg = (sh >= 64) ? 64'd0 : (a >> sh);
        base = int'(set_idx) * MAX_W;
        found = 1'b0;
        vacant = 1'b0;
        w = 0;
        for (i = 0; i < nw; i++)
        begin
            if (!found && line_ok[base + i] && line_tg[base + i] == tg)
            begin
                found = 1'b1;
                w = i;
            end
        end
        res = '0;
        if (found)
        begin
            age_lines(base, nw, w, int'(line_rank[base + w]));
            hit_cnt = sat_inc(hit_cnt);
        end
        else
        begin
            for (i = 0; i < nw; i++)
            begin
                if (!vacant && !line_ok[base + i])
                begin
                    vacant = 1'b1;
                    w = i;
                end
            end
            if (!vacant)
            begin
                w = 0;
                oldest = line_rank[base];
                for (i = 1; i < nw; i++)
                begin
                    if (line_rank[base + i] > oldest)
                    begin
                        oldest = line_rank[base + i];
                        w = i;
                    end
                end
            end
            line_tg[base + w] = tg;
            line_ok[base + w] = 1'b1;
            age_lines(base, nw, w, MAX_W);
            miss_cnt = sat_inc(miss_cnt);
            if (!vacant)
                evict_cnt = sat_inc(evict_cnt);
        end
        if (k == salc_pkg::KIND_MODIFY)
            hit_cnt = sat_inc(hit_cnt);
        res.hit       = found;
        res.evicted   = !found && !vacant;
        res.extra     = (k == salc_pkg::KIND_MODIFY);
        res.way       = w[2:0];
        res.hits      = hit_cnt;
        res.misses    = miss_cnt;
        res.evictions = evict_cnt;
    endtask

    task automatic sender_gap(input bit quiet);
        if (!quiet && $urandom_range(0, 99) < 18)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic issue_access(input script_row_t row);
        cache_outcome_t res;
        start       <= 1'b1;
        address     <= row.addr;
        access_kind <= row.kind;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_access(row.addr, row.kind, res);
        if (row.typed)
        begin
            res.hit     = row.hit;
            res.evicted = row.evicted;
            res.extra   = (row.kind == salc_pkg::KIND_MODIFY);
            res.way     = row.way;
        end
        outcome_q.push_back(res);
        accesses++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
        start <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            salc_pkg::CFG_SET_BITS:    cfg_sb   = val[2:0];
            salc_pkg::CFG_WAYS_IN_USE: cfg_ways = val[3:0];
            salc_pkg::CFG_BLOCK_BITS:  cfg_bb   = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    // mostly reuse of recent blocks and short tags, so hits and conflicts are common
    task automatic pick_address(output logic [63:0] a);
        int          r;
        int          span;
        logic [63:0] mask;
        r = $urandom_range(0, 99);
        span = int'(cfg_bb) + ((int'(cfg_sb) > MAX_SB) ? MAX_SB : int'(cfg_sb)) + 3;
        mask = (span >= 64) ? '1 : ((64'd1 << span) - 64'd1);
        if (r < 65 && addr_pool.size() > 0)
            a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
        else
        begin
            a = {$urandom, $urandom};
            if (r < 92)
                a = a & mask;
            addr_pool.push_back(a);
            if (addr_pool.size() > 16)
                void'(addr_pool.pop_front());
        end
    endtask

    always @(posedge clk)
    begin
        cache_outcome_t got;
        cache_outcome_t want;
        if (rst_n && done)
        begin
            got = {was_hit, was_evicted, extra_hit, chosen_way,
                   total_hits, total_misses, total_evictions};
            seen_hits      += int'(was_hit);
            seen_misses    += int'(!was_hit);
            seen_evictions += int'(was_evicted);
            seen_modifies  += int'(extra_hit);
            if (outcome_q.size() == 0)
            begin
                fails++;
                if (fails <= SHOW_LIMIT)
                    $display("unexpected result beat at %0t", $realtime);
            end
            else
            begin
                want = outcome_q.pop_front();
                if (got != want)
                begin
                    fails++;
                    if (fails <= SHOW_LIMIT)
                    begin
                        $display("mismatch exp: hit=%0b evict=%0b extra=%0b way=%0d",
                                 want.hit, want.evicted, want.extra, want.way);
                        $display("  exp totals: hits=%0d misses=%0d evictions=%0d",
                                 want.hits, want.misses, want.evictions);
                        $display("         got: hit=%0b evict=%0b extra=%0b way=%0d",
                                 got.hit, got.evicted, got.extra, got.way);
                        $display("  got totals: hits=%0d misses=%0d evictions=%0d",
                                 got.hits, got.misses, got.evictions);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || (rst_n && done) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        script_row_t row;
        int          ph;
        int          n;
        int          r;
        logic [63:0] a;
        rst_n       = 1'b0;
        start       = 1'b0;
        address     = '0;
        access_kind = KIND_LOAD;
        cfg_valid   = 1'b0;
        cfg_index   = salc_pkg::CFG_SET_BITS;
        cfg_data    = '0;
        stall_cycles = 0;
        fails = 0;
        accesses = 0;
        reg_writes = 0;
        seen_hits = 0;
        seen_misses = 0;
        seen_evictions = 0;
        seen_modifies = 0;
        for (n = 0; n < LINES; n++)
        begin
            line_ok[n]   = 1'b0;
            line_tg[n]   = '0;
            line_rank[n] = '0;
        end
        hit_cnt   = '0;
        miss_cnt  = '0;
        evict_cnt = '0;
        cfg_sb    = salc_pkg::SET_BITS_RST;
        cfg_ways  = salc_pkg::WAYS_IN_USE_RST;
        cfg_bb    = salc_pkg::BLOCK_BITS_RST;

        // reset settings: 16 sets, one way, 16-byte blocks
        script.push_back(row_typed(64'h0, KIND_LOAD, 1'b0, 1'b0, 3'd0));
        script.push_back(row_typed(64'h0, KIND_STORE, 1'b1, 1'b0, 3'd0));
        script.push_back(row_typed(64'h8, salc_pkg::KIND_MODIFY, 1'b1, 1'b0, 3'd0));
        script.push_back(row_typed(64'h100, KIND_LOAD, 1'b0, 1'b1, 3'd0));
        script.push_back(row_typed('1, KIND_UNKNOWN, 1'b0, 1'b0, 3'd0));
        script.push_back(row_typed('1, salc_pkg::KIND_MODIFY, 1'b1, 1'b0, 3'd0));
        // fill set 0 across eight ways, then lru victim
        script.push_back(row_write(salc_pkg::CFG_WAYS_IN_USE, 6'd8));
        for (n = 1; n < 8; n++)
            script.push_back(row_typed(64'(n + 1) << 8, KIND_LOAD, 1'b0, 1'b0, n[2:0]));
        script.push_back(row_typed(64'h100, KIND_STORE, 1'b1, 1'b0, 3'd0));
        script.push_back(row_typed(64'h900, KIND_LOAD, 1'b0, 1'b1, 3'd1));
        // out-of-range settings and full shifts
        script.push_back(row_write(salc_pkg::CFG_WAYS_IN_USE, 6'd15));
        script.push_back(row_write(salc_pkg::CFG_SET_BITS, 6'd7));
        script.push_back(row_write(salc_pkg::CFG_BLOCK_BITS, 6'd0));
        script.push_back(row_access(64'h0, salc_pkg::KIND_MODIFY));
        script.push_back(row_access('1, KIND_STORE));
        script.push_back(row_write(salc_pkg::CFG_BLOCK_BITS, 6'd63));
        script.push_back(row_access(64'h1234, KIND_LOAD));
        script.push_back(row_access(64'h8000_0000_0000_0000, KIND_UNKNOWN));
        script.push_back(row_write(salc_pkg::CFG_WAYS_IN_USE, 6'd0));
        script.push_back(row_write(salc_pkg::CFG_SET_BITS, 6'd0));
        script.push_back(row_access(64'h5555_5555_5555_5555, salc_pkg::KIND_MODIFY));
        script.push_back(row_access(64'hAAAA_AAAA_AAAA_AAAA, KIND_LOAD));
        script.push_back(row_write(salc_pkg::CFG_BLOCK_BITS, 6'd32));
        script.push_back(row_write(salc_pkg::CFG_SET_BITS, 6'd6));
        script.push_back(row_write(salc_pkg::CFG_WAYS_IN_USE, 6'd4));
        script.push_back(row_access(64'hFFFF_FFFF_0000_0000, KIND_LOAD));
        script.push_back(row_access(64'h0000_0001_0000_0000, KIND_STORE));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_write)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
            begin
                sender_gap(1'b0);
                issue_access(script[i]);
            end
        end
        directed_accesses = accesses;

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            r = $urandom_range(0, 9);
            write_reg(salc_pkg::CFG_SET_BITS, (r < 7) ? 6'($urandom_range(0, 4)) :
                                              (r == 7) ? 6'd6 : (r == 8) ? 6'd7 :
                                              6'($urandom_range(0, 7)));
            r = $urandom_range(0, 9);
            write_reg(salc_pkg::CFG_WAYS_IN_USE, (r < 7) ? 6'($urandom_range(1, 8)) :
                                                 (r == 7) ? 6'd0 : (r == 8) ? 6'd15 :
                                                 6'($urandom_range(9, 15)));
            r = $urandom_range(0, 9);
            write_reg(salc_pkg::CFG_BLOCK_BITS, (r < 6) ? 6'($urandom_range(0, 8)) :
                                                (r == 6) ? 6'd0 : (r == 7) ? 6'd32 :
                                                (r == 8) ? 6'd63 : 6'($urandom_range(9, 63)));
            for (n = 0; n < RAND_ITEMS; n++)
            begin
                pick_address(a);
                row = row_access(a, 2'($urandom_range(0, 3)));
                // phases 5 to 7 run back to back with no gaps
                sender_gap(ph >= 5 && ph <= 7);
                issue_access(row);
            end
        end

        start <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        fails += outcome_q.size();

        $display("ran %0d accesses (%0d directed) under %0d register writes",
                 accesses, directed_accesses, reg_writes);
        $display("results: %0d hits, %0d misses, %0d evictions, %0d modifies",
                 seen_hits, seen_misses, seen_evictions, seen_modifies);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
